/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files that carry checks (here the top-level search module).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/steq_pkg.sv */
// Shared widths, codes and controller/datapath types of the sorted table search.
package steq_pkg;

    localparam int KEY_W           = 16;
    localparam int TAG_W           = 16;
    localparam int IDX_W           = 6;
    localparam int CMD_W           = 2;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // read address sources; the selected index also loads mid or pos
    localparam int RD_W = 3;
    localparam logic [RD_W-1:0] RD_NONE     = 3'd0;
    localparam logic [RD_W-1:0] RD_MID_INIT = 3'd1;
    localparam logic [RD_W-1:0] RD_MID_NEXT = 3'd2;
    localparam logic [RD_W-1:0] RD_MID_DN   = 3'd3;
    localparam logic [RD_W-1:0] RD_POS_DN   = 3'd4;
    localparam logic [RD_W-1:0] RD_MID_UP   = 3'd5;
    localparam logic [RD_W-1:0] RD_POS_UP   = 3'd6;

    typedef struct packed {
        logic            clear;
        logic            append;
        logic            search_load;
        logic            bis_update;
        logic            push_mid;
        logic            push_pos;
        logic            finish;
        logic [RD_W-1:0] rd_src;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic bis_more;
        logic n_zero;
        logic mid_zero;
        logic pos_zero;
        logic mid_up_ok;
        logic pos_up_ok;
        logic out_free;
        logic pend_valid;
    } t_dp_stat;

endpackage

/* rtl/core/steq_in_if.sv */
// Command channel: valid/ready handshake with command, key and record tag.
interface steq_in_if;
    import steq_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] record_tag;

    modport source (output valid, output command, output key, output record_tag,
                    input ready);
    modport sink   (input valid, input command, input key, input record_tag,
                    output ready);
endinterface

/* rtl/core/steq_out_if.sv */
// Result channel: valid/ready handshake with one search result.
interface steq_out_if;
    import steq_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [TAG_W-1:0] match_tag;
    logic [IDX_W-1:0] match_index;
    logic             last;

    modport source (output valid, output found, output match_tag, output match_index,
                    output last, input ready);
    modport sink   (input valid, input found, input match_tag, input match_index,
                    input last, output ready);
endinterface

/* rtl/core/sorted_table_equal_range_search.sv */
// Sorted key/tag table with bisection search reporting every equal-key entry.
//
// i_in carries commands: clear (count to zero), append (store key and tag at
// the next position, dropped when the table is full) and search. o_out carries
// search results: found, match_tag, match_index and last on the final result.
// A search reports the probe hit, then matches below it in descending order,
// then matches above it in ascending order; with no match, or an empty table,
// it gives one result with found low and last high.
// Clear and append are done without leaving the idle state. A search runs
// P bisection probes (at most log2(TABLE_DEPTH) + 1, i.e. 7 for 64 entries),
// then S neighbor reads (one per match beside the probe hit, plus up to two
// misses that end the scans), and the final push; the single table read port
// sets one probe or scan step a cycle while the output register is free.
// Each match is held in a pending register until the next match or the final
// push moves it into the output register.
// i_in.ready is low while a search runs. A stalled receiver holds the output
// register, and the sequencer waits until it is free; new commands are taken
// as soon as a search has pushed its final result. Reset empties the table and
// drops any result in flight; the table memory itself is not cleared.
`include "assert_macros.svh"

module sorted_table_equal_range_search #(
    parameter int TABLE_DEPTH = steq_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    steq_in_if.sink     i_in,
    steq_out_if.source  o_out
);
    import steq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    steq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .o_ready   (i_in.ready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    steq_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_in.key),
        .i_record_tag (i_in.record_tag),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_out        (o_out)
    );

    // no held-back match may survive into the idle state
    `ASSERT_IMP(a_idle_no_pending, i_clk, i_rst_n, i_in.ready, !dp_stat.pend_valid)
    // a not-found result always closes its search
    `ASSERT_IMP(a_miss_is_last, i_clk, i_rst_n, o_out.valid && !o_out.found, o_out.last)
    // a search transfer always makes the sequencer busy
    `ASSERT_NXT(a_search_busy, i_clk, i_rst_n,
        i_in.valid && i_in.ready && (i_in.command == CMD_SEARCH), !i_in.ready)
    // results enter the output register only when it can take them
    `ASSERT_IMP(a_push_out_free, i_clk, i_rst_n,
        dp_cmd.push_mid || dp_cmd.push_pos || dp_cmd.finish, dp_stat.out_free)

endmodule

/* rtl/core/steq_ctrl.sv */
// Search sequencer: decodes commands and steps bisection and neighbor scans.
module steq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [steq_pkg::CMD_W-1:0] i_command,
    output logic                      o_ready,
    input  steq_pkg::t_dp_stat        i_stat,
    output steq_pkg::t_dp_cmd         o_cmd
);
    import steq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROBE  = 3'd1;
    localparam logic [2:0] S_DOWN   = 3'd2;
    localparam logic [2:0] S_UP     = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        logic scan_down;
        logic scan_up;
        scan_down = 1'b0;
        scan_up   = 1'b0;
        n_state   = r_state;
        o_cmd     = '0;
        o_ready   = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_CLEAR:  o_cmd.clear  = 1'b1;
                        CMD_APPEND: o_cmd.append = 1'b1;
                        CMD_SEARCH: begin
                            o_cmd.search_load = 1'b1;
                            if (i_stat.n_zero) begin
                                n_state = S_FINISH;
                            end else begin
                                o_cmd.rd_src = RD_MID_INIT;
                                n_state      = S_PROBE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PROBE: begin
                if (i_stat.out_free) begin
                    if (i_stat.hit) begin
                        o_cmd.push_mid = 1'b1;
                        scan_down      = 1'b1;
                    end else begin
                        o_cmd.bis_update = 1'b1;
                        if (i_stat.bis_more) o_cmd.rd_src = RD_MID_NEXT;
                        else                 scan_down    = 1'b1;
                    end
                end
            end
            S_DOWN: begin
                if (i_stat.out_free) begin
                    if (i_stat.hit) begin
                        o_cmd.push_pos = 1'b1;
                        if (i_stat.pos_zero) scan_up      = 1'b1;
                        else                 o_cmd.rd_src = RD_POS_DN;
                    end else begin
                        scan_up = 1'b1;
                    end
                end
            end
            S_UP: begin
                if (i_stat.out_free) begin
                    if (i_stat.hit) begin
                        o_cmd.push_pos = 1'b1;
                        if (i_stat.pos_up_ok) o_cmd.rd_src = RD_POS_UP;
                        else                  n_state      = S_FINISH;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // downward scan starts below the last probe point
        if (scan_down) begin
            if (i_stat.mid_zero) begin
                scan_up = 1'b1;
            end else begin
                o_cmd.rd_src = RD_MID_DN;
                n_state      = S_DOWN;
            end
        end
        if (scan_up) begin
            if (i_stat.mid_up_ok) begin
                o_cmd.rd_src = RD_MID_UP;
                n_state      = S_UP;
            end else begin
                n_state = S_FINISH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* rtl/core/steq_datapath.sv */
// Table storage, bisection bounds, scan index, pending result and output register.
module steq_datapath #(
    parameter int TABLE_DEPTH = steq_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [steq_pkg::KEY_W-1:0] i_key,
    input  logic [steq_pkg::TAG_W-1:0] i_record_tag,
    input  steq_pkg::t_dp_cmd         i_cmd,
    output steq_pkg::t_dp_stat        o_stat,
    steq_out_if.source                o_out
);
    import steq_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0] r_key_mem [TABLE_DEPTH];
    logic [TAG_W-1:0] r_tag_mem [TABLE_DEPTH];

    logic [CW-1:0]    r_count;
    logic [KEY_W-1:0] r_key;
    logic [CW-1:0]    r_lo;
    logic [CW-1:0]    r_hi;     // exclusive upper bound
    logic [AW-1:0]    r_mid;
    logic [AW-1:0]    r_pos;
    logic [KEY_W-1:0] r_rd_key;
    logic [TAG_W-1:0] r_rd_tag;
    logic             r_pend_valid;
    logic [TAG_W-1:0] r_pend_tag;
    logic [AW-1:0]    r_pend_idx;
    logic             r_out_valid;
    logic             r_out_found;
    logic [TAG_W-1:0] r_out_tag;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_last;

    logic          full;
    logic          hit;
    logic          key_lt;
    logic [CW-1:0] mid_ext;
    logic [CW-1:0] n_lo;
    logic [CW-1:0] n_hi;
    logic [CW:0]   bound_sum;
    logic [AW-1:0] mid_next;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] mid_init;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          push;
    logic          out_take;

    assign full     = (r_count >= CW'(TABLE_DEPTH));
    assign hit      = (r_rd_key == r_key);
    assign key_lt   = (r_key < r_rd_key);
    assign mid_ext  = CW'(r_mid);
    assign n_lo     = key_lt ? r_lo : mid_ext + CW'(1);
    assign n_hi     = key_lt ? mid_ext : r_hi;
    assign bound_sum = {1'b0, n_lo} + {1'b0, n_hi} - (CW + 1)'(1);
    assign mid_next = AW'(bound_sum >> 1);
    assign count_m1 = r_count - CW'(1);
    assign mid_init = AW'(count_m1 >> 1);
    assign push     = i_cmd.push_mid | i_cmd.push_pos;
    assign out_take = r_out_valid & o_out.ready;

    always_comb begin
        case (i_cmd.rd_src)
            RD_MID_INIT: rd_addr = mid_init;
            RD_MID_NEXT: rd_addr = mid_next;
            RD_MID_DN:   rd_addr = r_mid - AW'(1);
            RD_POS_DN:   rd_addr = r_pos - AW'(1);
            RD_MID_UP:   rd_addr = r_mid + AW'(1);
            RD_POS_UP:   rd_addr = r_pos + AW'(1);
            default:     rd_addr = r_mid;
        endcase
    end
    assign rd_en = (i_cmd.rd_src != RD_NONE);

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_key_mem[AW'(r_count)] <= i_key;
            r_tag_mem[AW'(r_count)] <= i_record_tag;
        end
        if (rd_en) begin
            r_rd_key <= r_key_mem[rd_addr];
            r_rd_tag <= r_tag_mem[rd_addr];
        end
    end

    // search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_load) begin
            r_key <= i_key;
            r_lo  <= '0;
            r_hi  <= r_count;
        end
        if (i_cmd.bis_update) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        case (i_cmd.rd_src)
            RD_MID_INIT, RD_MID_NEXT:        r_mid <= rd_addr;
            RD_MID_DN, RD_POS_DN,
            RD_MID_UP, RD_POS_UP:            r_pos <= rd_addr;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear)                r_count <= '0;
            else if (i_cmd.append && !full) r_count <= r_count + CW'(1);
            if (push)              r_pend_valid <= 1'b1;
            else if (i_cmd.finish) r_pend_valid <= 1'b0;
            if ((push && r_pend_valid) || i_cmd.finish) r_out_valid <= 1'b1;
            else if (out_take)                          r_out_valid <= 1'b0;
        end
    end

    // a match is held back one step so that last can be set on the final one
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_pend_tag <= r_rd_tag;
            r_pend_idx <= i_cmd.push_mid ? r_mid : r_pos;
            if (r_pend_valid) begin
                r_out_found <= 1'b1;
                r_out_tag   <= r_pend_tag;
                r_out_idx   <= IDX_W'(r_pend_idx);
                r_out_last  <= 1'b0;
            end
        end else if (i_cmd.finish) begin
            r_out_found <= r_pend_valid;
            r_out_tag   <= r_pend_valid ? r_pend_tag : '0;
            r_out_idx   <= r_pend_valid ? IDX_W'(r_pend_idx) : '0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.match_tag   = r_out_tag;
    assign o_out.match_index = r_out_idx;
    assign o_out.last        = r_out_last;

    assign o_stat.hit        = hit;
    assign o_stat.bis_more   = (n_lo < n_hi);
    assign o_stat.n_zero     = (r_count == '0);
    assign o_stat.mid_zero   = (r_mid == '0);
    assign o_stat.pos_zero   = (r_pos == '0);
    assign o_stat.mid_up_ok  = ((mid_ext + CW'(1)) < r_count);
    assign o_stat.pos_up_ok  = ((CW'(r_pos) + CW'(1)) < r_count);
    assign o_stat.out_free   = !r_out_valid || o_out.ready;
    assign o_stat.pend_valid = r_pend_valid;

endmodule
